>>> rtl/pca_pkg.sv
`default_nettype none
package pca_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_VERTICES = 1024;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int S_W      = 46;
    localparam int W_W      = 64;
    localparam int AREA_W   = 44;
    localparam int DEN_W    = 48;
    localparam int QUO_W    = 17;
    localparam int DIVD_W   = DEN_W + QUO_W;
    localparam int DCNT_W   = $clog2(QUO_W + 1);

    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    localparam logic [1:0] HINT_OUTER = 2'd0;
    localparam logic [1:0] HINT_HOLE  = 2'd1;

    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic diff;
        logic mulx;
        logic muly;
        logic upd;
        logic absval;
        logic den;
        logic div_start;
        logic div_sel_y;
        logic take_x;
        logic take_y;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic do_mac;
        logic last;
        logic s_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/pca_div.sv
`default_nettype none
module pca_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [pca_pkg::W_W-1:0]       i_num,
    input  wire [pca_pkg::DEN_W-1:0]     i_den,
    output logic                         o_done,
    output logic [pca_pkg::QUO_W-1:0]    o_quo,
    output logic                         o_ovf
);
    import pca_pkg::*;

    logic [W_W-1:0]    r_rem;
    logic [DIVD_W-1:0] r_d;
    logic [QUO_W-1:0]  r_q;
    logic              r_ovf;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVD_W:0]   w_diff;
    logic              w_ge;

    assign w_diff = {{(DIVD_W + 1 - W_W){1'b0}}, r_rem} - {1'b0, r_d};
    assign w_ge   = ~w_diff[DIVD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DCNT_W'(1);
            if (r_cnt == DCNT_W'(QUO_W)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // first step only checks the quotient against 2^QUO_W
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_d   <= {i_den, {QUO_W{1'b0}}};
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_d <= r_d >> 1;
            if (r_cnt == '0) begin
                r_ovf <= w_ge;
            end else begin
                r_q <= {r_q[QUO_W-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= w_diff[W_W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;

endmodule
`default_nettype wire

>>> rtl/pca_dp.sv
`default_nettype none
module pca_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  pca_pkg::t_cmd         i_cmd,
    output pca_pkg::t_sts         o_sts,
    input  wire signed [15:0]     i_vertex_x,
    input  wire signed [15:0]     i_vertex_y,
    input  wire [1:0]             i_hole_hint,
    input  wire                   i_last_vertex,
    input  wire                   i_out_stall,
    output logic                  o_out_valid,
    output logic signed [15:0]    o_centroid_x,
    output logic signed [15:0]    o_centroid_y,
    output logic [43:0]           o_area_times_two,
    output logic                  o_counter_clockwise,
    output logic                  o_is_hole,
    output logic                  o_needs_reversal,
    output logic                  o_ring_open,
    output logic                  o_vertex_overflow
);
    import pca_pkg::*;

    localparam logic [QUO_W-1:0] SAT_LIM = QUO_W'(1) << (COORD_BITS - 1);

    // captured beat
    logic signed [15:0] r_cur_x, r_cur_y;
    logic [1:0]         r_hint;
    logic               r_last;

    // ring state
    logic signed [15:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf_seen;
    logic signed [S_W-1:0] r_s;
    logic signed [W_W-1:0] r_wx, r_wy;

    // fan triangle
    logic signed [PROD_W-1:0]  r_p0, r_p1;
    logic signed [MUL_A_W-1:0] r_a2;
    logic signed [MUL_B_W-1:0] r_sx, r_sy;

    // ring end
    logic [S_W-1:0]     r_abs_s;
    logic               r_s_neg, r_s_zero;
    logic [DEN_W-1:0]   r_den;
    logic [15:0]        r_lx, r_ly;

    logic               w_full, w_do_mac;
    logic signed [16:0] w_dxp, w_dyp, w_dxc, w_dyc;
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic [W_W-1:0]     w_num;
    logic               w_div_done, w_div_ovf;
    logic [QUO_W-1:0]   w_quo;
    logic [15:0]        w_sat;
    logic signed [16:0] w_mid_x_sum, w_mid_y_sum;
    logic [16:0]        w_mid_x_adj, w_mid_y_adj;
    logic               w_ccw;
    logic               w_out_free;

    assign w_full   = (r_count >= CNT_W'(MAX_VERTICES));
    assign w_do_mac = (r_count >= CNT_W'(2)) && !w_full;

    assign w_dxp = 17'(r_prev_x) - 17'(r_first_x);
    assign w_dyp = 17'(r_prev_y) - 17'(r_first_y);
    assign w_dxc = 17'(r_cur_x) - 17'(r_first_x);
    assign w_dyc = 17'(r_cur_y) - 17'(r_first_y);

    // one shared multiplier for the four products of a fan triangle
    always_comb begin
        w_ma = MUL_A_W'(w_dxp);
        w_mb = MUL_B_W'(w_dyc);
        if (i_cmd.mul1) begin
            w_ma = MUL_A_W'(w_dxc);
            w_mb = MUL_B_W'(w_dyp);
        end else if (i_cmd.mulx) begin
            w_ma = r_a2;
            w_mb = r_sx;
        end else if (i_cmd.muly) begin
            w_ma = r_a2;
            w_mb = r_sy;
        end
    end

    assign w_prod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x <= i_vertex_x;
            r_cur_y <= i_vertex_y;
            r_hint  <= i_hole_hint;
            r_last  <= i_last_vertex;
        end
        if (i_cmd.mul0) begin
            r_p0 <= w_prod;
            r_sx <= MUL_B_W'(r_first_x) + MUL_B_W'(r_prev_x) + MUL_B_W'(r_cur_x);
            r_sy <= MUL_B_W'(r_first_y) + MUL_B_W'(r_prev_y) + MUL_B_W'(r_cur_y);
        end
        if (i_cmd.mul1) begin
            r_p1 <= w_prod;
        end
        if (i_cmd.diff) begin
            r_a2 <= r_p0[MUL_A_W-1:0] - r_p1[MUL_A_W-1:0];
        end
        if (i_cmd.mulx) begin
            r_p0 <= w_prod;
        end
        if (i_cmd.muly) begin
            r_p1 <= w_prod;
        end
        if (i_cmd.absval) begin
            r_abs_s  <= r_s[S_W-1] ? S_W'(-r_s) : S_W'(r_s);
            r_s_neg  <= r_s[S_W-1];
            r_s_zero <= (r_s == '0);
        end
        if (i_cmd.den) begin
            r_den <= {1'b0, r_abs_s, 1'b0} + {2'b00, r_abs_s};
        end
        if (i_cmd.take_x) begin
            r_lx <= w_sat;
        end
        if (i_cmd.take_y) begin
            r_ly <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_s        <= '0;
            r_wx       <= '0;
            r_wy       <= '0;
        end else begin
            if (i_cmd.mulx) begin
                r_s <= r_s + S_W'(r_a2);
            end
            if (i_cmd.muly) begin
                r_wx <= r_wx + W_W'(r_p0);
            end
            if (i_cmd.upd) begin
                if (w_full) begin
                    r_ovf_seen <= 1'b1;
                end else begin
                    if (r_count == '0) begin
                        r_first_x <= r_cur_x;
                        r_first_y <= r_cur_y;
                    end
                    if (w_do_mac) begin
                        r_wy <= r_wy + W_W'(r_p1);
                    end
                    r_prev_x <= r_cur_x;
                    r_prev_y <= r_cur_y;
                    r_count  <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // magnitude of the selected weighted sum into the shared divider
    always_comb begin
        w_num = i_cmd.div_sel_y ? r_wy : r_wx;
        if (w_num[W_W-1]) begin
            w_num = -w_num;
        end
    end

    pca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_ovf   (w_div_ovf)
    );

    // truncated quotient, saturated to the coordinate range
    always_comb begin
        logic neg;
        logic big;
        neg = (i_cmd.take_y ? r_wy[W_W-1] : r_wx[W_W-1]) ^ r_s_neg;
        big = w_div_ovf || (w_quo >= SAT_LIM);
        if (neg) begin
            w_sat = big ? 16'(SAT_LIM) : 16'(-w_quo);
        end else begin
            w_sat = big ? 16'(SAT_LIM - QUO_W'(1)) : w_quo[15:0];
        end
    end

    // zero-area fallback: midpoint of first and last, rounded toward zero
    assign w_mid_x_sum = 17'(r_first_x) + 17'(r_prev_x);
    assign w_mid_y_sum = 17'(r_first_y) + 17'(r_prev_y);
    assign w_mid_x_adj = w_mid_x_sum + {16'b0, w_mid_x_sum[16]};
    assign w_mid_y_adj = w_mid_y_sum + {16'b0, w_mid_y_sum[16]};

    assign w_ccw      = !r_s_neg && !r_s_zero;
    assign w_out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_centroid_x     <= r_s_zero ? w_mid_x_adj[16:1] : r_lx;
            o_centroid_y     <= r_s_zero ? w_mid_y_adj[16:1] : r_ly;
            o_area_times_two <= (r_abs_s > S_W'(AREA_MAX)) ? AREA_MAX
                                                           : r_abs_s[AREA_W-1:0];
            o_ring_open       <= (r_first_x != r_prev_x) || (r_first_y != r_prev_y);
            o_vertex_overflow <= r_ovf_seen;
            case (r_hint)
                HINT_HOLE: begin
                    o_counter_clockwise <= 1'b1;
                    o_is_hole           <= 1'b1;
                    o_needs_reversal    <= !w_ccw;
                end
                HINT_OUTER: begin
                    o_counter_clockwise <= 1'b0;
                    o_is_hole           <= 1'b0;
                    o_needs_reversal    <= w_ccw;
                end
                default: begin
                    o_counter_clockwise <= w_ccw;
                    o_is_hole           <= w_ccw;
                    o_needs_reversal    <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.do_mac   = w_do_mac;
    assign o_sts.last     = r_last;
    assign o_sts.s_zero   = r_s_zero;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = w_out_free;

endmodule
`default_nettype wire

>>> rtl/pca_ctrl.sv
`default_nettype none
module pca_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  pca_pkg::t_sts  i_sts,
    output pca_pkg::t_cmd  o_cmd
);
    import pca_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M0   = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_DIFF = 4'd3;
    localparam logic [3:0] ST_MX   = 4'd4;
    localparam logic [3:0] ST_MY   = 4'd5;
    localparam logic [3:0] ST_UPD  = 4'd6;
    localparam logic [3:0] ST_ABS  = 4'd7;
    localparam logic [3:0] ST_DEN  = 4'd8;
    localparam logic [3:0] ST_LDX  = 4'd9;
    localparam logic [3:0] ST_WX   = 4'd10;
    localparam logic [3:0] ST_LDY  = 4'd11;
    localparam logic [3:0] ST_WY   = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.do_mac ? ST_M0 : ST_UPD;
                end
            end
            ST_M0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = ST_M1;
            end
            ST_M1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_MX;
            end
            ST_MX: begin
                o_cmd.mulx = 1'b1;
                n_state    = ST_MY;
            end
            ST_MY: begin
                o_cmd.muly = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.last ? ST_ABS : ST_IDLE;
            end
            ST_ABS: begin
                o_cmd.absval = 1'b1;
                n_state      = ST_DEN;
            end
            ST_DEN: begin
                o_cmd.den = 1'b1;
                n_state   = i_sts.s_zero ? ST_OUT : ST_LDX;
            end
            ST_LDX: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_WX;
            end
            ST_WX: begin
                if (i_sts.div_done) begin
                    o_cmd.take_x = 1'b1;
                    n_state      = ST_LDY;
                end
            end
            ST_LDY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state         = ST_WY;
            end
            ST_WY: begin
                if (i_sts.div_done) begin
                    o_cmd.take_y = 1'b1;
                    n_state      = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold here until the output stage can take the beat
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/polygon_centroid_area.sv
// Channel   Direction  Handshake                 Beat
// vertex    in         i_in_valid / o_in_stall   x, y, hole_hint, last_vertex
// result    out        o_out_valid / i_out_stall centroid, area, direction, flags
//
// A fan vertex (third and later) uses one shared 35x18 multiplier, which
// forms the two cross products and the two weighted terms in turn. Other
// vertices are only loaded and updated. Ring end runs the bit-serial divider
// once per axis, 18 steps each, and skips it on zero area.
// Reset is synchronous and clears the sequencer, ring state and output valid.
// Vertices of the next ring are taken while a result waits; ring end holds
// until the output stage is free.
`default_nettype none
module polygon_centroid_area (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire signed [15:0]  i_vertex_x,
    input  wire signed [15:0]  i_vertex_y,
    input  wire [1:0]          i_hole_hint,
    input  wire                i_last_vertex,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [15:0] o_centroid_x,
    output logic signed [15:0] o_centroid_y,
    output logic [43:0]        o_area_times_two,
    output logic               o_counter_clockwise,
    output logic               o_is_hole,
    output logic               o_needs_reversal,
    output logic               o_ring_open,
    output logic               o_vertex_overflow
);
    import pca_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pca_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_vertex_x          (i_vertex_x),
        .i_vertex_y          (i_vertex_y),
        .i_hole_hint         (i_hole_hint),
        .i_last_vertex       (i_last_vertex),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_centroid_x        (o_centroid_x),
        .o_centroid_y        (o_centroid_y),
        .o_area_times_two    (o_area_times_two),
        .o_counter_clockwise (o_counter_clockwise),
        .o_is_hole           (o_is_hole),
        .o_needs_reversal    (o_needs_reversal),
        .o_ring_open         (o_ring_open),
        .o_vertex_overflow   (o_vertex_overflow)
    );

endmodule
`default_nettype wire

>>> rtl/pca_checker.sv
`default_nettype none
module pca_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire signed [15:0] i_vertex_x,
    input wire signed [15:0] i_vertex_y,
    input wire [1:0]         i_hole_hint,
    input wire               i_last_vertex,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [15:0] o_centroid_x,
    input wire signed [15:0] o_centroid_y,
    input wire [43:0]        o_area_times_two,
    input wire               o_counter_clockwise,
    input wire               o_is_hole,
    input wire               o_needs_reversal,
    input wire               o_ring_open,
    input wire               o_vertex_overflow
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_centroid_x)
            && $stable(o_centroid_y) && $stable(o_area_times_two))
        else $error("result beat changed while stalled");

    // every vertex taken is followed by a stall on the input
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("vertex taken on consecutive cycles");

    // after the hint is applied the hole decision always follows direction
    a_hole_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_hole == o_counter_clockwise))
        else $error("hole flag disagrees with direction");

    // a zero-area ring reads as clockwise unless reversed
    a_zero_cw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_area_times_two == 44'd0) && !o_needs_reversal
            |-> !o_counter_clockwise)
        else $error("zero-area ring reported counterclockwise");

    // a new result is loaded only while the input side is busy
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

endmodule

bind polygon_centroid_area pca_checker u_pca_checker (.*);
`default_nettype wire
